@@ sv/ofps_pkg.sv @@
// ----------------------------------------------------------------------------
// ofps_pkg
// shared field widths and the q1.15 twiddle table
// ----------------------------------------------------------------------------
package ofps_pkg;

    localparam int SAMPLE_W = 16;
    localparam int HOP_W    = 7;
    localparam int BIN_W    = 6;
    localparam int POWER_W  = 31;
    localparam int TW_IDX_W = 6;

    localparam logic [POWER_W-1:0] POWER_MAX = 31'd1073741824;
    localparam logic [HOP_W-1:0]   HOP_RESET = 7'd32;

    function automatic logic signed [15:0] quarter_cos(input logic [4:0] q);
        logic signed [15:0] v;
        case (q)
            5'd0:    v = 16'sd32767;
            5'd1:    v = 16'sd32610;
            5'd2:    v = 16'sd32138;
            5'd3:    v = 16'sd31357;
            5'd4:    v = 16'sd30274;
            5'd5:    v = 16'sd28899;
            5'd6:    v = 16'sd27246;
            5'd7:    v = 16'sd25330;
            5'd8:    v = 16'sd23170;
            5'd9:    v = 16'sd20788;
            5'd10:   v = 16'sd18205;
            5'd11:   v = 16'sd15447;
            5'd12:   v = 16'sd12540;
            5'd13:   v = 16'sd9512;
            5'd14:   v = 16'sd6393;
            5'd15:   v = 16'sd3212;
            default: v = 16'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] twiddle_cos(input logic [TW_IDX_W-1:0] m);
        logic [6:0] q;
        logic signed [15:0] v;
        q = {1'b0, m};
        if (q <= 7'd16) begin
            v = quarter_cos(q[4:0]);
        end else if (q <= 7'd32) begin
            v = -quarter_cos(5'(7'd32 - q));
        end else if (q <= 7'd48) begin
            v = -quarter_cos(5'(q - 7'd32));
        end else begin
            v = quarter_cos(5'(7'd64 - q));
        end
        return v;
    endfunction

endpackage

@@ sv/ofps_ram.sv @@
// ----------------------------------------------------------------------------
// ofps_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module ofps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ sv/overlapped_fft_power_spectrum.sv @@
// ----------------------------------------------------------------------------
// overlapped_fft_power_spectrum
// sliding-frame real dft power spectrum with peak bin report
// ----------------------------------------------------------------------------
// Samples enter on the s_ channel one word at a time into a circular frame
// memory. After hop_size new words the block computes bins 0..FFT_SIZE/2 and
// sends one m_ word per bin; the last word carries last_bin and the peak.
// While a frame is being transformed s_ready is low.
// For each bin the sequencer does one multiply-accumulate per frame entry,
// limited by the single read port of the frame memory, then drains the
// pipeline, scales and squares the result in states SQ0 to SQ2 and loads
// the output register in EMIT. A sample that does not complete a frame is
// only written into the frame memory.
// A stalled receiver holds the result in the output register and the
// sequencer waits before loading the next bin.
// Reset and every cfg_wr_en write clear the frame through per-entry valid
// bits at once (no clearing pass) and reload the sample counter.
// ----------------------------------------------------------------------------
module overlapped_fft_power_spectrum #(
    parameter int FFT_SIZE = 64
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [ofps_pkg::HOP_W-1:0]           cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [ofps_pkg::SAMPLE_W-1:0] s_sample,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [ofps_pkg::BIN_W-1:0]           m_bin_index,
    output logic [ofps_pkg::POWER_W-1:0]         m_bin_power,
    output logic                                 m_last_bin,
    output logic [ofps_pkg::BIN_W-1:0]           m_peak_bin,
    output logic [ofps_pkg::POWER_W-1:0]         m_peak_power
);
    import ofps_pkg::*;

    localparam int LOG2N   = $clog2(FFT_SIZE);
    localparam int CNT_W   = LOG2N + 1;
    localparam int ACC_W   = LOG2N + 32;
    localparam int SH      = LOG2N + 7;
    localparam int R_W     = ACC_W - SH;
    localparam int SQ_W    = 2 * R_W + 1;
    localparam int PW_W    = SQ_W - 16;
    localparam int STEP_SH = 6 - LOG2N;
    localparam logic [CNT_W-1:0] N_CNT = CNT_W'(FFT_SIZE);
    localparam logic [LOG2N-1:0] HALF  = LOG2N'(FFT_SIZE / 2);

    typedef enum logic [2:0] {IDLE, MAC, SQ0, SQ1, SQ2, EMIT} state_t;

    state_t                    state_reg;
    logic [HOP_W-1:0]          hop_reg;
    logic [HOP_W-1:0]          need_reg;
    logic [LOG2N-1:0]          base_reg;
    logic [FFT_SIZE-1:0]       valid_reg;
    logic [LOG2N-1:0]          k_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [TW_IDX_W-1:0]       m_reg;
    logic                      v1_reg, v2_reg, vld1_reg;
    logic [TW_IDX_W-1:0]       mc1_reg, ms1_reg;
    logic signed [31:0]        pre_reg, pim_reg;
    logic signed [ACC_W-1:0]   acc_re_reg, acc_im_reg;
    logic [R_W-1:0]            r_reg, i_reg;
    logic [SQ_W-1:0]           sq_reg;
    logic [POWER_W-1:0]        peak_pw_reg;
    logic [LOG2N-1:0]          peak_bin_reg;
    logic                      m_valid_reg, m_last_reg;
    logic [BIN_W-1:0]          m_bin_reg, m_pbin_reg;
    logic [POWER_W-1:0]        m_pw_reg, m_ppw_reg;

    logic [HOP_W-1:0]          eff_hop;
    logic [HOP_W-1:0]          cfg_eff;
    logic                      s_fire;
    logic [LOG2N-1:0]          wr_addr;
    logic [LOG2N-1:0]          rd_addr;
    logic [SAMPLE_W-1:0]       rd_data;
    logic signed [SAMPLE_W-1:0] x1;
    logic                      issue;
    logic [TW_IDX_W-1:0]       m_step;
    logic [ACC_W-1:0]          mag_re, mag_im;
    logic [ACC_W-1:0]          rnd_re, rnd_im;
    logic [PW_W-1:0]           pw_full;
    logic [POWER_W-1:0]        pw;
    logic                      out_free;
    logic                      emit_load;

    function automatic logic [HOP_W-1:0] clamp_hop(input logic [HOP_W-1:0] h);
        logic [HOP_W-1:0] r;
        r = h;
        if (h == '0) begin
            r = HOP_W'(1);
        end else if ({1'b0, h} > (HOP_W+1)'(FFT_SIZE)) begin
            r = HOP_W'(FFT_SIZE);
        end
        return r;
    endfunction

    assign eff_hop = clamp_hop(hop_reg);
    assign cfg_eff = clamp_hop(cfg_wr_data);
    assign s_ready = (state_reg == IDLE);
    assign s_fire  = s_valid && s_ready;
    assign wr_addr = base_reg + LOG2N'(HOP_W'(FFT_SIZE) - need_reg);
    assign issue   = (state_reg == MAC) && (cnt_reg < N_CNT);
    assign rd_addr = base_reg + cnt_reg[LOG2N-1:0];
    assign m_step  = TW_IDX_W'({{(TW_IDX_W-LOG2N){1'b0}}, k_reg} << STEP_SH);
    assign x1      = vld1_reg ? signed'(rd_data) : '0;

    assign mag_re  = acc_re_reg[ACC_W-1] ? ACC_W'(-acc_re_reg) : ACC_W'(acc_re_reg);
    assign mag_im  = acc_im_reg[ACC_W-1] ? ACC_W'(-acc_im_reg) : ACC_W'(acc_im_reg);
    assign rnd_re  = (mag_re + (ACC_W'(1) << (SH - 1))) >> SH;
    assign rnd_im  = (mag_im + (ACC_W'(1) << (SH - 1))) >> SH;
    assign pw_full = PW_W'((sq_reg + SQ_W'(32768)) >> 16);
    assign pw      = (pw_full > PW_W'(POWER_MAX)) ? POWER_MAX : POWER_W'(pw_full);
    assign out_free = !m_valid_reg || m_ready;
    assign emit_load = (state_reg == EMIT) && out_free;

    ofps_ram #(.WIDTH(SAMPLE_W), .DEPTH(FFT_SIZE)) u_frame (
        .aclk    (aclk),
        .wr_en   (s_fire),
        .wr_addr (wr_addr),
        .wr_data (s_sample),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            hop_reg     <= HOP_RESET;
            need_reg    <= clamp_hop(HOP_RESET);
            base_reg    <= '0;
            valid_reg   <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            k_reg       <= '0;
            cnt_reg     <= '0;
        end else begin
            if (emit_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            v1_reg   <= issue;
            v2_reg   <= v1_reg;
            vld1_reg <= valid_reg[rd_addr];
            mc1_reg  <= m_reg;
            ms1_reg  <= m_reg + TW_IDX_W'(48);
            pre_reg  <= x1 * twiddle_cos(mc1_reg);
            pim_reg  <= x1 * twiddle_cos(ms1_reg);
            if (v2_reg) begin
                acc_re_reg <= acc_re_reg + ACC_W'(pre_reg);
                acc_im_reg <= acc_im_reg - ACC_W'(pim_reg);
            end
            if (cfg_wr_en) begin
                hop_reg   <= cfg_wr_data;
                need_reg  <= cfg_eff;
                valid_reg <= '0;
                base_reg  <= '0;
            end
            unique case (state_reg)
                IDLE: begin
                    if (s_fire) begin
                        valid_reg[wr_addr] <= 1'b1;
                        need_reg <= need_reg - HOP_W'(1);
                        if (need_reg == HOP_W'(1)) begin
                            state_reg   <= MAC;
                            k_reg       <= '0;
                            cnt_reg     <= '0;
                            m_reg       <= '0;
                            acc_re_reg  <= '0;
                            acc_im_reg  <= '0;
                            peak_pw_reg <= '0;
                            peak_bin_reg <= '0;
                        end
                    end
                end
                MAC: begin
                    if (issue) begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                        m_reg   <= m_reg + m_step;
                    end else if (!v1_reg && !v2_reg) begin
                        state_reg <= SQ0;
                    end
                end
                SQ0: begin
                    r_reg     <= R_W'(rnd_re);
                    i_reg     <= R_W'(rnd_im);
                    state_reg <= SQ1;
                end
                SQ1: begin
                    sq_reg    <= SQ_W'(r_reg * r_reg);
                    state_reg <= SQ2;
                end
                SQ2: begin
                    sq_reg    <= sq_reg + SQ_W'(i_reg * i_reg);
                    state_reg <= EMIT;
                end
                EMIT: begin
                    if (out_free) begin
                        m_bin_reg   <= BIN_W'(k_reg);
                        m_pw_reg    <= pw;
                        m_last_reg  <= (k_reg == HALF);
                        m_pbin_reg  <= '0;
                        m_ppw_reg   <= '0;
                        if (pw > peak_pw_reg) begin
                            peak_pw_reg  <= pw;
                            peak_bin_reg <= k_reg;
                        end
                        if (k_reg == HALF) begin
                            m_pbin_reg <= (pw > peak_pw_reg) ? BIN_W'(k_reg)
                                                             : BIN_W'(peak_bin_reg);
                            m_ppw_reg  <= (pw > peak_pw_reg) ? pw : peak_pw_reg;
                            base_reg   <= base_reg + LOG2N'(eff_hop);
                            need_reg   <= eff_hop;
                            state_reg  <= IDLE;
                        end else begin
                            k_reg      <= k_reg + LOG2N'(1);
                            cnt_reg    <= '0;
                            m_reg      <= '0;
                            acc_re_reg <= '0;
                            acc_im_reg <= '0;
                            state_reg  <= MAC;
                        end
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_bin_index  = m_bin_reg;
    assign m_bin_power  = m_pw_reg;
    assign m_last_bin   = m_last_reg;
    assign m_peak_bin   = m_pbin_reg;
    assign m_peak_power = m_ppw_reg;

endmodule

@@ sv/ofps_checker.sv @@
// ----------------------------------------------------------------------------
// ofps_checker
// port-level checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
module ofps_checker #(
    parameter int FFT_SIZE = 64
) (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic [ofps_pkg::BIN_W-1:0]           m_bin_index,
    input logic [ofps_pkg::POWER_W-1:0]         m_bin_power,
    input logic                                 m_last_bin,
    input logic [ofps_pkg::BIN_W-1:0]           m_peak_bin,
    input logic [ofps_pkg::POWER_W-1:0]         m_peak_power
);
    import ofps_pkg::*;

    localparam logic [BIN_W-1:0] HALF = BIN_W'(FFT_SIZE / 2);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_bin_index) && $stable(m_bin_power))
        else $error("result word changed while stalled");

    a_last_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_bin == (m_bin_index == HALF)))
        else $error("last_bin not on final bin");

    a_peak_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_bin |-> m_peak_bin == '0 && m_peak_power == '0)
        else $error("peak fields nonzero before last bin");

    a_peak_ge: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_bin |-> m_bin_power <= m_peak_power && m_peak_power <= POWER_MAX)
        else $error("peak power inconsistent");

endmodule

bind overlapped_fft_power_spectrum ofps_checker #(.FFT_SIZE(FFT_SIZE)) u_ofps_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_bin_index  (m_bin_index),
    .m_bin_power  (m_bin_power),
    .m_last_bin   (m_last_bin),
    .m_peak_bin   (m_peak_bin),
    .m_peak_power (m_peak_power)
);

@@ dv/tb_overlapped_fft_power_spectrum.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_overlapped_fft_power_spectrum
// self-checking bench for the sliding-frame dft power spectrum
// ----------------------------------------------------------------------------
// Sends directed and random audio sample words through the s_ channel under
// several hop settings, each one written while the block is idle. A local
// spectrum predictor keeps its own copy of the frame and sample counter and
// computes every bin power and the peak for each completed frame. The m_
// words are compared field by field against the queue of predicted bins,
// under phases of sender idling, receiver stalling and one long receiver hold.
// ----------------------------------------------------------------------------
module tb_overlapped_fft_power_spectrum;
    import ofps_pkg::*;

    localparam int N_PTS      = 64;
    localparam int N_BINS     = N_PTS / 2 + 1;
    localparam int CYCLE_MAX  = 10000000;

    typedef struct packed {
        logic [BIN_W-1:0]   bin_index;
        logic [POWER_W-1:0] bin_power;
        logic               last_bin;
        logic [BIN_W-1:0]   peak_bin;
        logic [POWER_W-1:0] peak_power;
    } bin_word_t;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    localparam int COS_Q [17] = '{32767, 32610, 32138, 31357, 30274, 28899, 27246,
        25330, 23170, 20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_wr_en;
    logic [HOP_W-1:0]           cfg_wr_data;
    logic                       s_valid;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample;
    logic                       m_valid;
    logic                       m_ready;
    logic [BIN_W-1:0]           m_bin_index;
    logic [POWER_W-1:0]         m_bin_power;
    logic                       m_last_bin;
    logic [BIN_W-1:0]           m_peak_bin;
    logic [POWER_W-1:0]         m_peak_power;

    logic signed [SAMPLE_W-1:0] sample_queue[$];
    bin_word_t                  bin_queue[$];
    logic signed [15:0]         frame_copy[N_PTS];
    int unsigned                hop_reg;
    int unsigned                need_cnt;
    idle_mode_t                 idle_mode;
    int unsigned                hold_cycles;
    int unsigned                cycle_cnt;
    int unsigned                err_cnt;

    overlapped_fft_power_spectrum #(.FFT_SIZE(N_PTS)) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample     (s_sample),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_bin_index  (m_bin_index),
        .m_bin_power  (m_bin_power),
        .m_last_bin   (m_last_bin),
        .m_peak_bin   (m_peak_bin),
        .m_peak_power (m_peak_power)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    function automatic longint cos_q15(int unsigned m);
        int unsigned q;
        q = m & 63;
        if (q <= 16) return COS_Q[q];
        if (q <= 32) return -COS_Q[32 - q];
        if (q <= 48) return -COS_Q[q - 32];
        return COS_Q[64 - q];
    endfunction

    function automatic int unsigned hop_eff();
        int unsigned h;
        h = hop_reg & 127;
        if (h == 0) h = 1;
        if (h > N_PTS) h = N_PTS;
        return h;
    endfunction

    function automatic longint mag_q8(longint acc);
        longint a;
        a = (acc < 0) ? -acc : acc;
        return (a + N_PTS * 64) / (N_PTS * 128);
    endfunction

    function automatic void set_hop(int unsigned value);
        hop_reg = value & 127;
        foreach (frame_copy[i]) frame_copy[i] = '0;
        need_cnt = hop_eff();
    endfunction

    // frame update and spectrum for one accepted sample word
    function automatic void predict_spectrum(logic signed [15:0] x);
        int unsigned h;
        longint re, im, r, i, p, pk_pow;
        int unsigned pk_bin;
        bin_word_t w;
        h = hop_eff();
        if (need_cnt == 0 || need_cnt > N_PTS) need_cnt = h;
        frame_copy[(N_PTS - need_cnt) & 63] = x;
        need_cnt--;
        if (need_cnt != 0) return;
        pk_pow = 0;
        pk_bin = 0;
        for (int k = 0; k < N_BINS; k++) begin
            re = 0;
            im = 0;
            for (int n = 0; n < N_PTS; n++) begin
                re += longint'(frame_copy[n]) * cos_q15(k * n);
                im -= longint'(frame_copy[n]) * cos_q15(((k * n) & 63) + 48);
            end
            r = mag_q8(re);
            i = mag_q8(im);
            p = (r * r + i * i + 32768) >>> 16;
            if (p > longint'(POWER_MAX)) p = POWER_MAX;
            if (p > pk_pow) begin
                pk_pow = p;
                pk_bin = k;
            end
            w = '0;
            w.bin_index = BIN_W'(k);
            w.bin_power = POWER_W'(p);
            if (k == N_BINS - 1) begin
                w.last_bin   = 1'b1;
                w.peak_bin   = BIN_W'(pk_bin);
                w.peak_power = POWER_W'(pk_pow);
            end
            bin_queue.push_back(w);
        end
        need_cnt = h;
        for (int n = 0; n < N_PTS - int'(h); n++) frame_copy[n] = frame_copy[n + h];
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_cnt);
        err_cnt++;
    endtask

    function automatic bit roll_idle(bit sender_side);
        case (idle_mode)
            IDLE_SEND: return sender_side && ($urandom_range(99) < 56);
            IDLE_RECV: return !sender_side && ($urandom_range(99) < 56);
            IDLE_BOTH: return $urandom_range(99) < 8;
            default:   return 1'b0;
        endcase
    endfunction

    // driver
    always @(posedge aclk) begin
        bit take;
        take = s_valid && s_ready;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            s_sample <= '0;
        end else begin
            if (take) predict_spectrum(s_sample);
            if ((!s_valid || take) && sample_queue.size() > 0 && !roll_idle(1'b1)) begin
                s_valid  <= 1'b1;
                s_sample <= sample_queue.pop_front();
            end else if (take) begin
                s_valid <= 1'b0;
            end
        end
    end

    // long receiver hold
    always @(posedge aclk) begin
        if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    end

    // monitor
    always @(posedge aclk) begin
        bin_word_t w;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (bin_queue.size() == 0) begin
                    report_mismatch("unexpected word bin_index", m_bin_index, -1);
                end else begin
                    w = bin_queue.pop_front();
                    if (m_bin_index !== w.bin_index)
                        report_mismatch("bin_index", m_bin_index, w.bin_index);
                    if (m_bin_power !== w.bin_power)
                        report_mismatch("bin_power", m_bin_power, w.bin_power);
                    if (m_last_bin !== w.last_bin)
                        report_mismatch("last_bin", m_last_bin, w.last_bin);
                    if (m_peak_bin !== w.peak_bin)
                        report_mismatch("peak_bin", m_peak_bin, w.peak_bin);
                    if (m_peak_power !== w.peak_power)
                        report_mismatch("peak_power", m_peak_power, w.peak_power);
                end
            end
            m_ready <= (hold_cycles == 0) && !roll_idle(1'b0);
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_MAX) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic signed [15:0] make_sample(int kind, int tone, int amp, int n);
        case (kind)
            0:       return 16'($urandom);
            1:       return 16'(int'($urandom_range(64)) - 32);
            2:       return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            default: return 16'((cos_q15(tone * n) * amp) >>> 15);
        endcase
    endfunction

    task automatic wait_idle();
        while (sample_queue.size() > 0 || s_valid || bin_queue.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_hop(int unsigned value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= HOP_W'(value);
        set_hop(value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic load_random(int count);
        int kind, tone, amp;
        kind = $urandom_range(3);
        tone = $urandom_range(32);
        amp  = $urandom_range(32768);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(15) == 0) kind = $urandom_range(3);
            sample_queue.push_back(make_sample(kind, tone, amp, n));
        end
    endtask

    initial begin
        int unsigned h;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_sample    = '0;
        m_ready     = 1'b0;
        hold_cycles = 0;
        cycle_cnt   = 0;
        err_cnt     = 0;
        idle_mode   = IDLE_NONE;
        set_hop(HOP_RESET);
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset hop: extremes, dc, alternating and impulses
        foreach (frame_copy[i]) ;
        sample_queue = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0001, 16'sh7fff,
            16'sh8000, 16'sh7fff, 16'sh8000, 16'sh5555, 16'shaaaa, 16'sh0000, 16'sh0000};
        for (int n = 0; n < 19; n++) sample_queue.push_back(16'sh8000);
        for (int n = 0; n < 32; n++)
            sample_queue.push_back(n[0] ? 16'sh7fff : 16'sh8000);
        wait_idle();

        // full hop, long receiver hold that stalls the block with samples still queued
        write_hop(64);
        idle_mode   = IDLE_SEND;
        hold_cycles = 6000;
        for (int n = 0; n < 64; n++) sample_queue.push_back(16'sh8000);
        load_random(8);
        wait_idle();

        write_hop(1);
        idle_mode = IDLE_RECV;
        load_random(24);
        wait_idle();

        write_hop(0);
        idle_mode = IDLE_BOTH;
        load_random(6);
        wait_idle();

        // hop above frame size, clamped to it; sender pauses halfway through the frame
        write_hop(100);
        idle_mode = IDLE_NONE;
        load_random(32);
        wait_idle();
        load_random(32);
        wait_idle();

        write_hop(127);
        idle_mode = IDLE_RECV;
        load_random(64);
        wait_idle();

        for (int ph = 0; ph < 6; ph++) begin
            h = $urandom_range(2, 64);
            write_hop(h);
            idle_mode = idle_mode_t'(ph % 4);
            load_random(h < 16 ? 2 * h : 20);
            wait_idle();
        end

        write_hop(32);
        idle_mode = IDLE_BOTH;
        load_random(32);
        wait_idle();
        repeat (100) @(posedge aclk);

        if (err_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
